// ----- hdl/pcg32_pkg.sv -----
// ----------------------------------------------------------------------------
// pcg32_pkg
// Shared types, constants and the output permutation of the PCG32 XSH-RR
// generator.
// ----------------------------------------------------------------------------
package pcg32_pkg;

  localparam logic [63:0] LCG_MULT    = 64'd6364136223846793005;
  localparam logic [63:0] LCG_STREAM  = 64'd54;
  localparam logic [63:0] LCG_INC     = (LCG_STREAM << 1) | 64'd1;
  // state after seeding with zero: (0 * mult + inc + 0) * mult + inc
  localparam logic [63:0] RESET_STATE = LCG_INC * LCG_MULT + LCG_INC;

  localparam int XSH_SHIFT = 18;
  localparam int OUT_LSB   = 27;
  localparam int ROT_LSB   = 59;

  localparam logic [1:0] OP_RESEED  = 2'd0;
  localparam logic [1:0] OP_RAW     = 2'd1;
  localparam logic [1:0] OP_FRAC    = 2'd2;
  localparam logic [1:0] OP_BOUNDED = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RESEED,
    ST_THR,
    ST_DRAW,
    ST_MOD,
    ST_FIN
  } pcg_state_t;

  function automatic logic [31:0] permute(input logic [63:0] old);
    logic [63:0] xs;
    logic [31:0] mixed;
    logic [4:0]  rot;
    logic [63:0] dbl;
    xs    = old ^ (old >> XSH_SHIFT);
    mixed = xs[OUT_LSB +: 32];
    rot   = old[ROT_LSB +: 5];
    dbl   = {mixed, mixed} >> rot;
    return dbl[31:0];
  endfunction

endpackage

// ----- hdl/pcg32_lcg.sv -----
// ----------------------------------------------------------------------------
// pcg32_lcg
// One LCG advance, state * mult + inc mod 2^64, on a single 32x32 multiplier
// over three partial products.
// ----------------------------------------------------------------------------
module pcg32_lcg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] state_in,
  output logic        done,
  output logic [63:0] state_out
);

  logic        busy_r;
  logic [1:0]  cnt_r;
  logic        done_r;
  logic [63:0] a_r;
  logic [63:0] prod_r;
  logic [63:0] acc_r;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] product;

  always_comb begin
    case (cnt_r)
      2'd0: begin
        mul_a = a_r[31:0];
        mul_b = pcg32_pkg::LCG_MULT[31:0];
      end
      2'd1: begin
        mul_a = a_r[31:0];
        mul_b = pcg32_pkg::LCG_MULT[63:32];
      end
      default: begin
        mul_a = a_r[63:32];
        mul_b = pcg32_pkg::LCG_MULT[31:0];
      end
    endcase
    product = {32'd0, mul_a} * {32'd0, mul_b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 2'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 2'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= state_in;
    end else if (busy_r) begin
      prod_r <= product;
      case (cnt_r)
        2'd1: acc_r <= prod_r + pcg32_pkg::LCG_INC;
        2'd2: acc_r[63:32] <= acc_r[63:32] + prod_r[31:0];
        2'd3: acc_r[63:32] <= acc_r[63:32] + prod_r[31:0];
        default: ;
      endcase
    end
  end

  assign done      = done_r;
  assign state_out = acc_r;

endmodule

// ----- hdl/pcg32_div.sv -----
// ----------------------------------------------------------------------------
// pcg32_div
// Restoring 32-bit divider, one quotient bit a cycle; only the remainder is
// kept.
// ----------------------------------------------------------------------------
module pcg32_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] remainder
);

  logic        busy_r;
  logic [4:0]  cnt_r;
  logic        done_r;
  logic [31:0] rem_r;
  logic [31:0] q_r;
  logic [31:0] dvs_r;
  logic [32:0] shifted;
  logic [32:0] diff;
  logic [31:0] rem_nxt;

  always_comb begin
    shifted = {rem_r, q_r[31]};
    diff    = shifted - {1'b0, dvs_r};
    rem_nxt = diff[32] ? shifted[31:0] : diff[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 5'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= 32'd0;
      q_r   <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[30:0], 1'b0};
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// ----- hdl/pcg32_random_generator.sv -----
// ----------------------------------------------------------------------------
// pcg32_random_generator
// PCG32 XSH-RR generator with reseed, raw word, 0.24 fraction and bounded
// integer operations.
//
// Input transactions carry op, low_bound and high_bound on in_tdata; one is
// taken at a time, and in_tready is low while an operation is in progress.
// A reseed gives no output transaction; every other op gives one on out_tdata.
// An LCG advance runs on one shared 32x32 multiplier. A raw word, fraction
// or full-span draw takes one LCG advance and then loads the output register.
// A bounded draw first finds the rejection threshold on the one-bit-a-cycle
// divider, then draws a word, takes its remainder on the divider and loads the
// output register; each rejected word costs one more LCG advance. A reseed is
// ready again once its advance is done. An empty range returns low_bound.
// The result sits in an output register, so a new transaction is accepted
// while out_tvalid waits for out_tready; a second result then waits until
// the first is taken.
// Reset (rst_n low, synchronous) clears the seed register and loads the state
// that seeding with zero gives. cfg_wr_en writes cfg_wr_data to the seed;
// it is used by the next reseed op.
// ----------------------------------------------------------------------------
module pcg32_random_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // op[1:0], low_bound[33:2], high_bound[65:34], zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata   // raw_word[31:0], fraction[55:32], bounded_value[87:56]
);

  pcg32_pkg::pcg_state_t state_r, state_nxt;

  logic [63:0] seed_r;
  logic [63:0] lcg_r;
  logic [1:0]  op_r;
  logic [31:0] lo_r;
  logic [31:0] range_r;
  logic [31:0] thr_r;
  logic [31:0] word_r;
  logic        full_r;
  logic [31:0] res_raw_r;
  logic [23:0] res_frac_r;
  logic [31:0] res_bnd_r;
  logic        out_valid_r;
  logic [87:0] out_data_r;

  logic [1:0]  in_op;
  logic [31:0] in_lo;
  logic [31:0] in_hi;
  logic [31:0] in_range;
  logic        in_fire;
  logic        in_empty;
  logic        in_full;
  logic        word_ok;
  logic        fin_go;

  logic        lcg_start;
  logic [63:0] lcg_in;
  logic        lcg_done;
  logic [63:0] lcg_res;
  logic        div_start;
  logic [31:0] div_dividend;
  logic [31:0] div_divisor;
  logic        div_done;
  logic [31:0] div_rem;

  assign in_op    = in_tdata[1:0];
  assign in_lo    = in_tdata[33:2];
  assign in_hi    = in_tdata[65:34];
  assign in_range = in_hi - in_lo + 32'd1;
  assign in_fire  = in_tvalid && in_tready;
  assign in_empty = $signed(in_lo) >= $signed(in_hi);
  assign in_full  = (in_range == 32'd0);
  assign word_ok  = (word_r >= thr_r);
  assign fin_go   = !out_valid_r || out_tready;

  assign in_tready = (state_r == pcg32_pkg::ST_IDLE);

  pcg32_lcg u_lcg (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (lcg_start),
    .state_in  (lcg_in),
    .done      (lcg_done),
    .state_out (lcg_res)
  );

  pcg32_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .remainder (div_rem)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pcg32_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            pcg32_pkg::OP_RESEED: state_nxt = pcg32_pkg::ST_RESEED;
            pcg32_pkg::OP_BOUNDED: begin
              if (in_empty) begin
                state_nxt = pcg32_pkg::ST_FIN;
              end else if (in_full) begin
                state_nxt = pcg32_pkg::ST_DRAW;
              end else begin
                state_nxt = pcg32_pkg::ST_THR;
              end
            end
            default: state_nxt = pcg32_pkg::ST_DRAW;
          endcase
        end
      end
      pcg32_pkg::ST_RESEED: begin
        if (lcg_done) state_nxt = pcg32_pkg::ST_IDLE;
      end
      pcg32_pkg::ST_THR: begin
        if (div_done) state_nxt = pcg32_pkg::ST_DRAW;
      end
      pcg32_pkg::ST_DRAW: begin
        if (lcg_done) begin
          if (op_r != pcg32_pkg::OP_BOUNDED || full_r) begin
            state_nxt = pcg32_pkg::ST_FIN;
          end else if (word_ok) begin
            state_nxt = pcg32_pkg::ST_MOD;
          end
        end
      end
      pcg32_pkg::ST_MOD: begin
        if (div_done) state_nxt = pcg32_pkg::ST_FIN;
      end
      pcg32_pkg::ST_FIN: begin
        if (fin_go) state_nxt = pcg32_pkg::ST_IDLE;
      end
      default: state_nxt = pcg32_pkg::ST_IDLE;
    endcase
  end

  // unit strobes
  always_comb begin
    lcg_start    = 1'b0;
    lcg_in       = lcg_r;
    div_start    = 1'b0;
    div_dividend = word_r;
    div_divisor  = range_r;
    case (state_r)
      pcg32_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            pcg32_pkg::OP_RESEED: begin
              lcg_start = 1'b1;
              lcg_in    = pcg32_pkg::LCG_INC + seed_r;
            end
            pcg32_pkg::OP_BOUNDED: begin
              if (!in_empty && in_full) begin
                lcg_start = 1'b1;
              end else if (!in_empty) begin
                div_start    = 1'b1;
                div_dividend = 32'd0 - in_range;
                div_divisor  = in_range;
              end
            end
            default: lcg_start = 1'b1;
          endcase
        end
      end
      pcg32_pkg::ST_THR: begin
        lcg_start = div_done;
      end
      pcg32_pkg::ST_DRAW: begin
        if (lcg_done && op_r == pcg32_pkg::OP_BOUNDED && !full_r) begin
          if (word_ok) begin
            div_start = 1'b1;
          end else begin
            lcg_start = 1'b1;
            lcg_in    = lcg_res;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcg32_pkg::ST_IDLE;
      seed_r      <= 64'd0;
      lcg_r       <= pcg32_pkg::RESET_STATE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) seed_r <= cfg_wr_data;
      if ((state_r == pcg32_pkg::ST_RESEED || state_r == pcg32_pkg::ST_DRAW) && lcg_done) begin
        lcg_r <= lcg_res;
      end
      if (state_r == pcg32_pkg::ST_FIN && fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      pcg32_pkg::ST_IDLE: begin
        if (in_fire) begin
          op_r       <= in_op;
          lo_r       <= in_lo;
          range_r    <= in_range;
          full_r     <= in_full;
          word_r     <= pcg32_pkg::permute(lcg_r);
          res_raw_r  <= 32'd0;
          res_frac_r <= 24'd0;
          if (in_op == pcg32_pkg::OP_BOUNDED && in_empty) begin
            res_bnd_r <= in_lo;
          end else begin
            res_bnd_r <= 32'd0;
          end
        end
      end
      pcg32_pkg::ST_THR: begin
        if (div_done) begin
          thr_r  <= div_rem;
          word_r <= pcg32_pkg::permute(lcg_r);
        end
      end
      pcg32_pkg::ST_DRAW: begin
        if (lcg_done) begin
          case (op_r)
            pcg32_pkg::OP_RAW:  res_raw_r  <= word_r;
            pcg32_pkg::OP_FRAC: res_frac_r <= word_r[31:8];
            default: begin
              if (full_r) begin
                res_bnd_r <= lo_r + word_r;
              end else if (!word_ok) begin
                word_r <= pcg32_pkg::permute(lcg_res);
              end
            end
          endcase
        end
      end
      pcg32_pkg::ST_MOD: begin
        if (div_done) res_bnd_r <= lo_r + div_rem;
      end
      pcg32_pkg::ST_FIN: begin
        if (fin_go) out_data_r <= {res_bnd_r, res_frac_r, res_raw_r};
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- verif/pcg32_random_generator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcg32_random_generator_test
// Self-checking bench for the PCG32 XSH-RR generator. A directed set covers
// the reset state, every op, empty and inverted ranges, the full 32-bit span
// and heavy rejection. Random phases follow, each with a new seed; all but
// two have random gaps on both channels, and one has a long output stall.
// Results are checked in order against a local model of the generator.
// ----------------------------------------------------------------------------
module pcg32_random_generator_test;

  localparam int          CLK_HALF        = 5;
  localparam int          RESET_CYCLES    = 8;
  localparam int          CYCLE_LIMIT     = 1000000;
  localparam int          PHASES          = 6;
  localparam int          ITEMS_PER_PHASE = 325;
  localparam int          SETTLE_CYCLES   = 40;
  localparam int          HOLD_CYCLES     = 300;
  localparam int          REPORT_LIMIT    = 10;
  localparam logic [63:0] GEN_MULT        = 64'd6364136223846793005;
  localparam logic [63:0] GEN_INC         = 64'd109;

  typedef struct packed {
    logic [31:0] bounded_value;
    logic [23:0] fraction;
    logic [31:0] raw_word;
  } gen_result_t;

  class pcg32_draw_tracker;
    logic [63:0] lcg;
    logic [63:0] seed;
    gen_result_t expected_draws[$];
    int          mismatches;

    function new();
      seed       = '0;
      mismatches = 0;
      reseed();
    endfunction

    function logic [31:0] draw_word();
      logic [63:0] old_state;
      logic [63:0] shifted;
      logic [31:0] mixed;
      logic [4:0]  rot;
      logic [4:0]  lrot;
      old_state = lcg;
      lcg       = old_state * GEN_MULT + GEN_INC;
      shifted   = (old_state ^ (old_state >> 18)) >> 27;
      mixed     = shifted[31:0];
      rot       = old_state[63:59];
      lrot      = -rot;
      return (mixed >> rot) | (mixed << lrot);
    endfunction

    function void reseed();
      lcg = '0;
      void'(draw_word());
      lcg = lcg + seed;
      void'(draw_word());
    endfunction

    function logic [31:0] bounded_draw(logic [31:0] lo, logic [31:0] hi);
      logic [31:0] span;
      logic [31:0] thr;
      logic [31:0] w;
      if ($signed(lo) >= $signed(hi)) return lo;
      span = hi - lo + 32'd1;
      if (span == 32'd0) return lo + draw_word();
      thr = (32'd0 - span) % span;
      do w = draw_word(); while (w < thr);
      return lo + (w % span);
    endfunction

    function void note_request(logic [1:0] op, logic [31:0] lo, logic [31:0] hi);
      gen_result_t r;
      logic [31:0] w;
      r = '0;
      if (op == pcg32_pkg::OP_RESEED) begin
        reseed();
      end else begin
        case (op)
          pcg32_pkg::OP_RAW: begin
            r.raw_word = draw_word();
          end
          pcg32_pkg::OP_FRAC: begin
            w          = draw_word();
            r.fraction = w[31:8];
          end
          pcg32_pkg::OP_BOUNDED: begin
            r.bounded_value = bounded_draw(lo, hi);
          end
          default: ;
        endcase
        expected_draws.push_back(r);
      end
    endfunction

    function void check_draw(logic [87:0] data);
      gen_result_t got;
      gen_result_t want;
      got = data;
      if (expected_draws.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: raw %h frac %h bounded %h",
                   got.raw_word, got.fraction, got.bounded_value);
      end else begin
        want = expected_draws.pop_front();
        if (got.raw_word !== want.raw_word || got.fraction !== want.fraction ||
            got.bounded_value !== want.bounded_value) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display({"draw mismatch: expected raw %h frac %h bounded %h, ",
                      "got raw %h frac %h bounded %h"},
                     want.raw_word, want.fraction, want.bounded_value,
                     got.raw_word, got.fraction, got.bounded_value);
        end
      end
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [63:0] cfg_wr_data = '0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata    = '0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [87:0] out_tdata;

  int                cycle_count  = 0;
  bit                idle_on      = 1'b1;
  bit                hold_off_req = 1'b0;
  pcg32_draw_tracker tracker;

  pcg32_random_generator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  task automatic send_item(logic [1:0] op, logic [31:0] lo, logic [31:0] hi);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, hi, lo, op};
    do @(posedge clk); while (!in_tready);
    tracker.note_request(op, lo, hi);
  endtask

  // drain, let a trailing reseed finish, then load the seed
  task automatic write_seed(logic [63:0] value);
    in_tvalid <= 1'b0;
    while (tracker.expected_draws.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    tracker.seed = value;
  endtask

  task automatic send_random_item();
    logic [1:0]  op;
    logic [31:0] lo;
    logic [31:0] hi;
    int          pick;
    pick = $urandom_range(0, 99);
    op   = (pick < 4)  ? pcg32_pkg::OP_RESEED :
           (pick < 28) ? pcg32_pkg::OP_RAW :
           (pick < 50) ? pcg32_pkg::OP_FRAC : pcg32_pkg::OP_BOUNDED;
    lo   = $urandom;
    hi   = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        hi = lo + $urandom_range(0, 255);
      end
      5: begin
        hi = lo;
      end
      6: begin
        lo = 32'h8000_0000;
        hi = 32'h7fff_ffff;
      end
      7: begin
        hi = lo + 32'h8000_0000 + $urandom_range(0, 15);
      end
      8: begin
        lo = {lo[1], {31{lo[0]}}};
        hi = {hi[1], {31{hi[0]}}};
      end
      9: begin
        hi = lo - $urandom_range(1, 1000);
      end
      default: begin
      end
    endcase
    send_item(op, lo, hi);
  endtask

  initial begin : receiver
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        stall = idle_on ? $urandom_range(0, 3) : 0;
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      tracker.check_draw(out_tdata);
    end
  end

  initial begin : stimulus
    logic [63:0] seed;
    tracker = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset state, empty and inverted ranges, full span, heavy rejection
    send_item(pcg32_pkg::OP_RAW, 32'h0000_0000, 32'h0000_0000);
    send_item(pcg32_pkg::OP_FRAC, 32'hffff_ffff, 32'hffff_ffff);
    send_item(pcg32_pkg::OP_BOUNDED, 32'h0000_0000, 32'h0000_0000);
    send_item(pcg32_pkg::OP_BOUNDED, 32'd5, 32'hffff_fffb);
    send_item(pcg32_pkg::OP_BOUNDED, 32'h7fff_ffff, 32'h8000_0000);
    send_item(pcg32_pkg::OP_BOUNDED, 32'h8000_0000, 32'h7fff_ffff);
    send_item(pcg32_pkg::OP_BOUNDED, 32'h0000_0000, 32'h0000_0001);
    send_item(pcg32_pkg::OP_BOUNDED, 32'hffff_ffff, 32'h0000_0000);
    send_item(pcg32_pkg::OP_BOUNDED, 32'h8000_0000, 32'h0000_0000);
    send_item(pcg32_pkg::OP_BOUNDED, 32'h8000_0000, 32'h8000_0001);
    send_item(pcg32_pkg::OP_BOUNDED, 32'h7fff_fffe, 32'h7fff_ffff);
    send_item(pcg32_pkg::OP_BOUNDED, 32'h0000_0000, 32'h7fff_ffff);
    send_item(pcg32_pkg::OP_BOUNDED, -1000, 1000);
    send_item(pcg32_pkg::OP_RESEED, 32'hffff_ffff, 32'hffff_ffff);
    send_item(pcg32_pkg::OP_RAW, 32'h0000_0000, 32'h0000_0000);

    write_seed(64'hffff_ffff_ffff_ffff);
    send_item(pcg32_pkg::OP_RESEED, 32'h0000_0000, 32'h0000_0000);
    send_item(pcg32_pkg::OP_RAW, 32'h0000_0000, 32'h0000_0000);
    send_item(pcg32_pkg::OP_FRAC, 32'h0000_0000, 32'h0000_0000);
    send_item(pcg32_pkg::OP_BOUNDED, 32'hffff_ff00, 32'hffff_ffff);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        1:       seed = 64'h0;
        3:       seed = 64'hffff_ffff_ffff_ffff;
        default: seed = {$urandom, $urandom};
      endcase
      write_seed(seed);
      idle_on = (phase % 3 != 2);
      send_item(pcg32_pkg::OP_RESEED, $urandom, $urandom);
      for (int n = 1; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 2 && n == 40) hold_off_req = 1'b1;
        send_random_item();
      end
    end

    in_tvalid <= 1'b0;
    while (tracker.expected_draws.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.expected_draws.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- pcg32_random_generator.f -----
hdl/pcg32_pkg.sv
hdl/pcg32_lcg.sv
hdl/pcg32_div.sv
hdl/pcg32_random_generator.sv
verif/pcg32_random_generator_test.sv
